@@ hw/rtl/segment_triangle_intersect_2d_top_assert.svh @@
// ----------------------------------------------------------------------------
// Segment / triangle intersection: assertion macros
// Concurrent assertion helpers sampled on clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_TRIANGLE_INTERSECT_2D_TOP_ASSERT_SVH
`define SEGMENT_TRIANGLE_INTERSECT_2D_TOP_ASSERT_SVH

// check a condition at every edge
`define STI2D_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// check a consequent sequence after an antecedent
`define STI2D_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error(msg);

`endif

@@ hw/rtl/sti2d_pkg.sv @@
// ----------------------------------------------------------------------------
// Segment / triangle intersection: package
// Shared types and constants for the front end, queue and back end.
// ----------------------------------------------------------------------------
package sti2d_pkg;

   localparam int CoordWidthDefault = 16;
   localparam int QueueDepth        = 8;
   localparam int QueuePtrWidth     = $clog2(QueueDepth);
   localparam int QueueCntWidth     = $clog2(QueueDepth + 1);
   localparam int CreditWidth       = $clog2(QueueDepth + 4);

   // three-way sign of a cross product
   typedef enum logic [1:0] {
      SGN_ZERO = 2'b00,
      SGN_POS  = 2'b01,
      SGN_NEG  = 2'b11
   } sign_type;

   // classified request: all side tests
   typedef struct packed {
      sign_type       orient;
      sign_type [2:0] seg_side;
      sign_type [2:0] side_p;
      sign_type [2:0] side_q;
   } class_type;

   typedef struct packed {
      logic       push;
      logic [1:0] inflight;
   } fstat_type;

   typedef struct packed {
      logic                     empty;
      logic [QueueCntWidth-1:0] count;
   } qstat_type;

endpackage

@@ hw/rtl/sti2d_side.sv @@
// ----------------------------------------------------------------------------
// Segment / triangle intersection: side test
// Three-stage sign of (V-U) x (W-U): differences, products, subtract and sign.
// ----------------------------------------------------------------------------
module sti2d_side #(
   parameter int COORD_WIDTH = sti2d_pkg::CoordWidthDefault
) (
   input  logic                          clock,
   input  logic signed [COORD_WIDTH-1:0] u_x,
   input  logic signed [COORD_WIDTH-1:0] u_y,
   input  logic signed [COORD_WIDTH-1:0] v_x,
   input  logic signed [COORD_WIDTH-1:0] v_y,
   input  logic signed [COORD_WIDTH-1:0] w_x,
   input  logic signed [COORD_WIDTH-1:0] w_y,
   output sti2d_pkg::sign_type           sgn
);
   import sti2d_pkg::*;

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * COORD_WIDTH + 2;
   localparam int SW = PW + 1;

   logic signed [DW-1:0] dvx_in, dvx_ff, dwy_in, dwy_ff;
   logic signed [DW-1:0] dvy_in, dvy_ff, dwx_in, dwx_ff;
   logic signed [PW-1:0] prod_a_in, prod_a_ff, prod_b_in, prod_b_ff;
   logic signed [SW-1:0] diff;
   sign_type             sgn_in, sgn_ff;

   always_comb begin
      dvx_in    = DW'(v_x) - DW'(u_x);
      dwy_in    = DW'(w_y) - DW'(u_y);
      dvy_in    = DW'(v_y) - DW'(u_y);
      dwx_in    = DW'(w_x) - DW'(u_x);
      prod_a_in = PW'(dvx_ff) * PW'(dwy_ff);
      prod_b_in = PW'(dvy_ff) * PW'(dwx_ff);
      diff      = SW'(prod_a_ff) - SW'(prod_b_ff);
      if (diff == '0) begin
         sgn_in = SGN_ZERO;
      end else if (diff[SW-1]) begin
         sgn_in = SGN_NEG;
      end else begin
         sgn_in = SGN_POS;
      end
   end

   always_ff @(posedge clock) begin
      dvx_ff    <= dvx_in;
      dwy_ff    <= dwy_in;
      dvy_ff    <= dvy_in;
      dwx_ff    <= dwx_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      sgn_ff    <= sgn_in;
   end

   assign sgn = sgn_ff;

endmodule

@@ hw/rtl/sti2d_front.sv @@
// ----------------------------------------------------------------------------
// Segment / triangle intersection: front end
// Accept a request and classify it by all ten side tests in a 3-stage pipe.
// ----------------------------------------------------------------------------
module sti2d_front #(
   parameter int COORD_WIDTH = sti2d_pkg::CoordWidthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic signed [COORD_WIDTH-1:0] p_x,
   input  logic signed [COORD_WIDTH-1:0] p_y,
   input  logic signed [COORD_WIDTH-1:0] q_x,
   input  logic signed [COORD_WIDTH-1:0] q_y,
   input  logic signed [COORD_WIDTH-1:0] a_x,
   input  logic signed [COORD_WIDTH-1:0] a_y,
   input  logic signed [COORD_WIDTH-1:0] b_x,
   input  logic signed [COORD_WIDTH-1:0] b_y,
   input  logic signed [COORD_WIDTH-1:0] c_x,
   input  logic signed [COORD_WIDTH-1:0] c_y,
   output sti2d_pkg::class_type          cls,
   output sti2d_pkg::fstat_type          stat
);
   import sti2d_pkg::*;

   logic signed [COORD_WIDTH-1:0] tx [3];
   logic signed [COORD_WIDTH-1:0] ty [3];
   logic [2:0]                    vld_in, vld_ff;

   assign tx[0] = a_x;
   assign ty[0] = a_y;
   assign tx[1] = b_x;
   assign ty[1] = b_y;
   assign tx[2] = c_x;
   assign ty[2] = c_y;

   sti2d_side #(.COORD_WIDTH(COORD_WIDTH)) u_orient (
      .clock (clock),
      .u_x   (a_x), .u_y (a_y),
      .v_x   (b_x), .v_y (b_y),
      .w_x   (c_x), .w_y (c_y),
      .sgn   (cls.orient)
   );

   for (genvar k = 0; k < 3; k++) begin : g_edge
      localparam int N = (k + 1) % 3;

      sti2d_side #(.COORD_WIDTH(COORD_WIDTH)) u_seg (
         .clock (clock),
         .u_x   (p_x),   .u_y (p_y),
         .v_x   (q_x),   .v_y (q_y),
         .w_x   (tx[k]), .w_y (ty[k]),
         .sgn   (cls.seg_side[k])
      );

      sti2d_side #(.COORD_WIDTH(COORD_WIDTH)) u_sp (
         .clock (clock),
         .u_x   (tx[k]), .u_y (ty[k]),
         .v_x   (tx[N]), .v_y (ty[N]),
         .w_x   (p_x),   .w_y (p_y),
         .sgn   (cls.side_p[k])
      );

      sti2d_side #(.COORD_WIDTH(COORD_WIDTH)) u_sq (
         .clock (clock),
         .u_x   (tx[k]), .u_y (ty[k]),
         .v_x   (tx[N]), .v_y (ty[N]),
         .w_x   (q_x),   .w_y (q_y),
         .sgn   (cls.side_q[k])
      );
   end

   always_comb begin
      vld_in        = {vld_ff[1:0], accept};
      stat.push     = vld_ff[2];
      stat.inflight = 2'(vld_ff[0]) + 2'(vld_ff[1]) + 2'(vld_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

endmodule

@@ hw/rtl/sti2d_queue.sv @@
// ----------------------------------------------------------------------------
// Segment / triangle intersection: class queue
// Short FIFO of classified requests between front end and back end.
// ----------------------------------------------------------------------------
module sti2d_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sti2d_pkg::class_type wr_data,
   input  logic                 pop,
   output sti2d_pkg::class_type rd_data,
   output sti2d_pkg::qstat_type stat
);
   import sti2d_pkg::*;

   class_type                mem_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_in, wr_ptr_ff, rd_ptr_in, rd_ptr_ff;
   logic [QueueCntWidth-1:0] count_in, count_ff;
   logic                     do_pop;

   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      rd_data    = mem_ff[rd_ptr_ff];
      stat.empty = (count_ff == '0);
      stat.count = count_ff;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/sti2d_back.sv @@
// ----------------------------------------------------------------------------
// Segment / triangle intersection: back end
// Resolve the edge rules in order AB, BC, CA and register the response.
// ----------------------------------------------------------------------------
module sti2d_back (
   input  logic                 clock,
   input  logic                 reset,
   input  sti2d_pkg::class_type head,
   input  sti2d_pkg::qstat_type qstat,
   output logic                 pop,
   output logic                 rsp_valid,
   output logic                 rsp_hit
);
   import sti2d_pkg::*;

   logic       found;
   logic       hit_in, hit_ff;
   logic       valid_in, valid_ff;
   logic [1:0] inner;
   sign_type   sp, sq;

   always_comb begin
      found = 1'b0;
      hit_in = 1'b0;
      inner = 2'd0;
      sp = SGN_ZERO;
      sq = SGN_ZERO;
      for (int k = 0; k < 3; k++) begin
         sp = head.side_p[k];
         sq = head.side_q[k];
         if (!found) begin
            if (sp == sq && sp != head.orient) begin
               found  = 1'b1;
               hit_in = 1'b0;
            end else begin
               if (sp == head.orient && sq == head.orient) begin
                  inner = inner + 2'd1;
               end
               if (sp != sq && head.seg_side[k] != head.seg_side[(k == 2) ? 0 : k + 1]) begin
                  found  = 1'b1;
                  hit_in = 1'b1;
               end
            end
         end
      end
      if (!found) begin
         hit_in = (inner == 2'd3);
      end
      pop      = !qstat.empty;
      valid_in = !qstat.empty;
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_hit   = hit_ff;

endmodule

@@ hw/rtl/segment_triangle_intersect_2d_top.sv @@
// ----------------------------------------------------------------------------
// Segment / triangle intersection: top level
// Tests a segment PQ against a triangle ABC, one request per cycle while busy is low.
// ----------------------------------------------------------------------------
// Requests: drive the ten req_ coordinates and raise start; the request is
// taken at a rising edge where start is high and busy is low. Coordinates
// are signed fixed point, COORD_WIDTH bits each.
// Responses: rsp_valid is high for exactly one cycle with rsp_hit beside it,
// one response per request, in request order. The receiver cannot stall.
// Path: a request passes three side-test stages, one queue stage and one
// response register before rsp_valid rises. Throughput: one request per
// cycle while busy is low; the side-test pipe is fully pipelined.
// busy rises while reset is high, and when the class queue plus requests in
// the side-test pipe reach the queue depth; with a receiver that never
// stalls the queue drains every cycle and busy stays low.
// Reset: synchronous, active high; clears the pipe valids, the queue and the
// response strobe. No request or response is in flight after reset.
// ----------------------------------------------------------------------------
module segment_triangle_intersect_2d_top #(
   parameter int COORD_WIDTH = sti2d_pkg::CoordWidthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_seg_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_seg_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_seg_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_vert_a_x,
   input  logic signed [COORD_WIDTH-1:0] req_vert_a_y,
   input  logic signed [COORD_WIDTH-1:0] req_vert_b_x,
   input  logic signed [COORD_WIDTH-1:0] req_vert_b_y,
   input  logic signed [COORD_WIDTH-1:0] req_vert_c_x,
   input  logic signed [COORD_WIDTH-1:0] req_vert_c_y,
   output logic                          rsp_valid,
   output logic                          rsp_hit
);
   import sti2d_pkg::*;

   `include "segment_triangle_intersect_2d_top_assert.svh"

   logic                   req_accept;
   logic                   pop;
   logic [CreditWidth-1:0] credit_total;
   class_type              front_cls, head_cls;
   fstat_type              fstat;
   qstat_type              qstat;

   always_comb begin
      credit_total = CreditWidth'(qstat.count) + CreditWidth'(fstat.inflight);
      busy         = reset || (credit_total >= CreditWidth'(QueueDepth));
      req_accept   = start && !busy;
   end

   sti2d_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .p_x    (req_seg_start_x),
      .p_y    (req_seg_start_y),
      .q_x    (req_seg_end_x),
      .q_y    (req_seg_end_y),
      .a_x    (req_vert_a_x),
      .a_y    (req_vert_a_y),
      .b_x    (req_vert_b_x),
      .b_y    (req_vert_b_y),
      .c_x    (req_vert_c_x),
      .c_y    (req_vert_c_y),
      .cls    (front_cls),
      .stat   (fstat)
   );

   sti2d_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (fstat.push),
      .wr_data (front_cls),
      .pop     (pop),
      .rd_data (head_cls),
      .stat    (qstat)
   );

   sti2d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head_cls),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_hit   (rsp_hit)
   );

   `STI2D_ASSERT_IMPLIES(a_req_gives_rsp, req_accept, ##5 rsp_valid, "request without response")
   `STI2D_ASSERT_IMPLIES(a_rsp_has_req, rsp_valid, $past(req_accept, 5), "response without request")
   `STI2D_ASSERT_ALWAYS(a_credit_bound, credit_total <= CreditWidth'(QueueDepth), "queue overrun")

endmodule

@@ bench/tb_segment_triangle_intersect_2d_top.sv @@
// ----------------------------------------------------------------------------
// Segment / triangle intersection: testbench
// Drives segment and triangle requests through the command port with random
// gaps and checks every hit flag against an exact cross-product predictor.
// Requests run in order, so each response is checked against the oldest
// prediction still outstanding.
// ----------------------------------------------------------------------------
module tb_segment_triangle_intersect_2d_top;
   import sti2d_pkg::*;

   localparam int CW            = CoordWidthDefault;
   localparam int RandomReqs    = 1750;
   localparam int IdleMax       = 18;
   localparam int WatchdogLimit = 1000;
   localparam int DrainCycles   = 12;
   localparam longint CoordMaxVal = (longint'(1) << (CW - 1)) - 1;
   localparam longint CoordMinVal = -(longint'(1) << (CW - 1));

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      point_type p;
      point_type q;
      point_type a;
      point_type b;
      point_type c;
   } seg_tri_req_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   logic            rsp_valid;
   logic            rsp_hit;
   seg_tri_req_type driven_req = '0;

   coord_type req_seg_start_x, req_seg_start_y, req_seg_end_x, req_seg_end_y;
   coord_type req_vert_a_x, req_vert_a_y, req_vert_b_x, req_vert_b_y;
   coord_type req_vert_c_x, req_vert_c_y;

   assign req_seg_start_x = driven_req.p.x;
   assign req_seg_start_y = driven_req.p.y;
   assign req_seg_end_x   = driven_req.q.x;
   assign req_seg_end_y   = driven_req.q.y;
   assign req_vert_a_x    = driven_req.a.x;
   assign req_vert_a_y    = driven_req.a.y;
   assign req_vert_b_x    = driven_req.b.x;
   assign req_vert_b_y    = driven_req.b.y;
   assign req_vert_c_x    = driven_req.c.x;
   assign req_vert_c_y    = driven_req.c.y;

   seg_tri_req_type pending_req_q[$];
   bit              hit_expected_q[$];
   logic            took_req    = 1'b0;
   int              idle_left   = 0;
   bit              no_gap_run  = 1'b0;
   int              stall_count = 0;
   int              fail_count  = 0;
   int              req_count   = 0;
   int              hit_seen    = 0;
   int              miss_seen   = 0;
   int              directed_count;
   bit              want_hit;

   segment_triangle_intersect_2d_top #(
      .COORD_WIDTH(CW)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_seg_start_x(req_seg_start_x),
      .req_seg_start_y(req_seg_start_y),
      .req_seg_end_x  (req_seg_end_x),
      .req_seg_end_y  (req_seg_end_y),
      .req_vert_a_x   (req_vert_a_x),
      .req_vert_a_y   (req_vert_a_y),
      .req_vert_b_x   (req_vert_b_x),
      .req_vert_b_y   (req_vert_b_y),
      .req_vert_c_x   (req_vert_c_x),
      .req_vert_c_y   (req_vert_c_y),
      .rsp_valid      (rsp_valid),
      .rsp_hit        (rsp_hit)
   );

   function automatic sign_type cross_sign(point_type u, point_type v, point_type w);
      longint ux, uy, cr;
      ux = longint'($signed(u.x));
      uy = longint'($signed(u.y));
      cr = (longint'($signed(v.x)) - ux) * (longint'($signed(w.y)) - uy)
         - (longint'($signed(v.y)) - uy) * (longint'($signed(w.x)) - ux);
      if (cr > 0) return SGN_POS;
      if (cr < 0) return SGN_NEG;
      return SGN_ZERO;
   endfunction

   function automatic bit predict_hit(seg_tri_req_type r);
      point_type vtx[3];
      sign_type  orient;
      sign_type  seg_s[3];
      sign_type  sp, sq;
      int        inner;
      vtx[0] = r.a;
      vtx[1] = r.b;
      vtx[2] = r.c;
      orient = cross_sign(r.a, r.b, r.c);
      for (int k = 0; k < 3; k++) seg_s[k] = cross_sign(r.p, r.q, vtx[k]);
      inner = 0;
      // edges in order AB, BC, CA; first deciding edge wins
      for (int k = 0; k < 3; k++) begin
         sp = cross_sign(vtx[k], vtx[(k + 1) % 3], r.p);
         sq = cross_sign(vtx[k], vtx[(k + 1) % 3], r.q);
         if (sp == sq && sp != orient) return 1'b0;
         if (sp == orient && sq == orient) inner++;
         if (sp != sq && seg_s[k] != seg_s[(k + 1) % 3]) return 1'b1;
      end
      return inner == 3;
   endfunction

   function automatic coord_type any_coord(bit wide);
      if (wide) return coord_type'($urandom);
      return coord_type'(int'($urandom_range(0, 4000)) - 2000);
   endfunction

   function automatic coord_type edge_coord();
      case ($urandom_range(0, 5))
         0: return coord_type'(CoordMinVal);
         1: return coord_type'(-1);
         2: return coord_type'(0);
         3: return coord_type'(1);
         4: return coord_type'(CoordMaxVal);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic point_type mid_point(point_type u, point_type v);
      point_type r;
      r.x = coord_type'((longint'($signed(u.x)) + longint'($signed(v.x))) / 2);
      r.y = coord_type'((longint'($signed(u.y)) + longint'($signed(v.y))) / 2);
      return r;
   endfunction

   function automatic point_type blend_point(point_type a, point_type b, point_type c);
      longint    wa, wb, wc, tot;
      point_type r;
      wa = $urandom_range(0, 15);
      wb = $urandom_range(0, 15);
      wc = $urandom_range(0, 15);
      if (wa + wb + wc == 0) wa = 1;
      tot = wa + wb + wc;
      r.x = coord_type'((wa * $signed(a.x) + wb * $signed(b.x) + wc * $signed(c.x)) / tot);
      r.y = coord_type'((wa * $signed(a.y) + wb * $signed(b.y) + wc * $signed(c.y)) / tot);
      return r;
   endfunction

   function automatic point_type anchor_point(seg_tri_req_type r, bit wide);
      point_type z;
      case ($urandom_range(0, 6))
         0: return r.a;
         1: return r.b;
         2: return r.c;
         3: return mid_point(r.a, r.b);
         4: return mid_point(r.b, r.c);
         5: return mid_point(r.c, r.a);
         default: begin
            z.x = any_coord(wide);
            z.y = any_coord(wide);
            return z;
         end
      endcase
   endfunction

   function automatic seg_tri_req_type random_request();
      seg_tri_req_type r;
      bit              wide;
      int              shape;
      wide  = $urandom_range(0, 1);
      shape = $urandom_range(0, 9);
      r = '0;
      r.a.x = any_coord(wide);
      r.a.y = any_coord(wide);
      r.b.x = any_coord(wide);
      r.b.y = any_coord(wide);
      r.c.x = any_coord(wide);
      r.c.y = any_coord(wide);
      r.p.x = any_coord(wide);
      r.p.y = any_coord(wide);
      r.q.x = any_coord(wide);
      r.q.y = any_coord(wide);
      case (shape)
         0, 1: r = seg_tri_req_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
         2: begin
            r.a.x = coord_type'(int'($urandom_range(0, 12)) - 6);
            r.a.y = coord_type'(int'($urandom_range(0, 12)) - 6);
            r.b.x = coord_type'(int'($urandom_range(0, 12)) - 6);
            r.b.y = coord_type'(int'($urandom_range(0, 12)) - 6);
            r.c.x = coord_type'(int'($urandom_range(0, 12)) - 6);
            r.c.y = coord_type'(int'($urandom_range(0, 12)) - 6);
            r.p.x = coord_type'(int'($urandom_range(0, 12)) - 6);
            r.p.y = coord_type'(int'($urandom_range(0, 12)) - 6);
            r.q.x = coord_type'(int'($urandom_range(0, 12)) - 6);
            r.q.y = coord_type'(int'($urandom_range(0, 12)) - 6);
         end
         3, 4, 5: begin
            r.p = blend_point(r.a, r.b, r.c);
            r.q = blend_point(r.a, r.b, r.c);
         end
         6: r.p = blend_point(r.a, r.b, r.c);
         7: begin
            r.p = anchor_point(r, wide);
            r.q = anchor_point(r, wide);
         end
         8: begin
            r.a.x = edge_coord();
            r.a.y = edge_coord();
            r.b.x = edge_coord();
            r.b.y = edge_coord();
            r.c.x = edge_coord();
            r.c.y = edge_coord();
            r.p.x = edge_coord();
            r.p.y = edge_coord();
            r.q.x = edge_coord();
            r.q.y = edge_coord();
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic add_req(int px, int py, int qx, int qy, int ax, int ay,
                          int bx, int by, int cx, int cy);
      seg_tri_req_type r;
      r.p.x = coord_type'(px);
      r.p.y = coord_type'(py);
      r.q.x = coord_type'(qx);
      r.q.y = coord_type'(qy);
      r.a.x = coord_type'(ax);
      r.a.y = coord_type'(ay);
      r.b.x = coord_type'(bx);
      r.b.y = coord_type'(by);
      r.c.x = coord_type'(cx);
      r.c.y = coord_type'(cy);
      pending_req_q.push_back(r);
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   always @(negedge clock) begin
      if (!reset && (!start || took_req)) begin
         if (idle_left > 0) begin
            idle_left <= idle_left - 1;
            start     <= 1'b0;
         end else if (pending_req_q.size() != 0) begin
            driven_req <= pending_req_q.pop_front();
            start      <= 1'b1;
            if ($urandom_range(0, 39) == 0) no_gap_run <= !no_gap_run;
            idle_left <= no_gap_run ? 0 : $urandom_range(0, IdleMax);
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      took_req <= !reset && start && !busy;
      if (!reset) begin
         if (start && !busy) begin
            hit_expected_q.push_back(predict_hit(driven_req));
            req_count++;
         end
         if (rsp_valid) begin
            if (hit_expected_q.size() == 0) begin
               $error("response with no request outstanding: hit=%0b", rsp_hit);
               fail_count++;
            end else begin
               want_hit = hit_expected_q.pop_front();
               if (rsp_hit !== want_hit) begin
                  $error("hit: expected %0b, actual %0b", want_hit, rsp_hit);
                  fail_count++;
               end
               if (want_hit) hit_seen++;
               else miss_seen++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         stall_count <= 0;
      end else if (stall_count >= WatchdogLimit) begin
         $display("watchdog: no progress for %0d cycles", WatchdogLimit);
         $display("Mismatches found");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   initial begin
      add_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_req(256, 256, 512, 512, 0, 0, 2560, 0, 0, 2560);
      add_req(256, 256, 512, 512, 0, 0, 0, 2560, 2560, 0);
      add_req(-256, 512, 512, 512, 0, 0, 2560, 0, 0, 2560);
      add_req(256, -256, 512, -512, 0, 0, 2560, 0, 0, 2560);
      add_req(0, 512, -256, 512, 0, 0, 2560, 0, 0, 2560);
      add_req(0, 0, -512, -512, 0, 0, 2560, 0, 0, 2560);
      add_req(-256, -256, 256, 256, 0, 0, 2560, 0, 0, 2560);
      add_req(-256, 0, 3000, 0, 0, 0, 2560, 0, 0, 2560);
      add_req(-512, 1024, 3500, 1024, 0, 0, 2560, 0, 0, 2560);
      add_req(0, 512, 512, 0, 0, 0, 256, 256, 512, 512);
      add_req(-256, 256, 256, -256, 100, 100, 100, 100, 100, 100);
      add_req(512, 512, 512, 512, 0, 0, 2560, 0, 0, 2560);
      add_req(-512, -512, -512, -512, 0, 0, 2560, 0, 0, 2560);
      add_req(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 32767, 32767);
      add_req(32767, -32768, -32768, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
      add_req(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
      add_req(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
              -32768);
      add_req(21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846, 21845, -21846);
      add_req(-1, -1, 1, 1, -32768, -32768, 32767, -32768, 0, 32767);
      add_req(-1, 1, 1, -1, 0, 0, 1, 0, 0, 1);
      add_req(-32768, 0, 32767, 0, -32768, -32768, 32767, -32768, 0, 32767);
      directed_count = pending_req_q.size();
      repeat (RandomReqs) pending_req_q.push_back(random_request());

      while (pending_req_q.size() != 0 || start || hit_expected_q.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (hit_expected_q.size() != 0) begin
         $error("%0d predicted responses never arrived", hit_expected_q.size());
         fail_count++;
      end
      $display("Ran %0d segment/triangle requests (%0d directed, rest random).",
               req_count, directed_count);
      $display("Responses checked: %0d hits, %0d misses.", hit_seen, miss_seen);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/sti2d_pkg.sv
hw/rtl/sti2d_side.sv
hw/rtl/sti2d_front.sv
hw/rtl/sti2d_queue.sv
hw/rtl/sti2d_back.sv
hw/rtl/segment_triangle_intersect_2d_top.sv
bench/tb_segment_triangle_intersect_2d_top.sv
